### rtl/sfd_pkg.sv
// Package for the serial frame deframer with additive checksum.
// Holds the phase, kind and status types, byte constants, register indexes
// and the result record. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // Frame parsing phases.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_CMD     = 4'd1,
    PH_LEN8    = 4'd2,
    PH_LENH    = 4'd3,
    PH_LENL    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_ETX     = 4'd6,
    PH_CSUM    = 4'd7,
    PH_CSUMBAD = 4'd8
  } phase_e;

  // Frame kinds as reported on the result channel.
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_EXT    = 2'd1,
    KIND_CMD    = 2'd2
  } kind_e;

  // Verdict codes.
  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD_ETX  = 3'd2,
    ST_BAD_CSUM = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  // Protocol bytes.
  localparam logic [7:0] SYNC_BYTE     = 8'h01;
  localparam logic [7:0] ETX_BYTE      = 8'h03;
  localparam logic [7:0] KIND_CMD_BYTE = 8'h13;
  localparam logic [7:0] KIND_EXT_BYTE = 8'h15;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SYNC_RUN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd1;
  localparam logic [2:0]  MIN_SYNC_RUN_RESET = 3'd3;
  localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd1017;

  // Largest sync run count held.
  localparam logic [2:0] SYNC_RUN_MAX = 3'd7;

  // One result item.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [16:0] byte_index;
    kind_e       frame_kind;
    logic [15:0] payload_length;
    logic        frame_end;
    status_e     status;
    logic        run_last;
  } res_t;

endpackage

`default_nettype wire

### rtl/sfd_in_if.sv
// Input byte channel of the serial frame deframer.
// Carries valid, ready and one received byte. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/sfd_out_if.sv
// Result channel of the serial frame deframer.
// Carries valid, ready and the fields of one result. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [16:0] byte_index;
  logic [1:0]  frame_kind;
  logic [15:0] payload_length;
  logic        frame_end;
  logic [2:0]  status;
  logic        run_last;

  modport source (output valid, output data_byte, output byte_index, output frame_kind,
                  output payload_length, output frame_end, output status,
                  output run_last, input ready);
  modport sink (input valid, input data_byte, input byte_index, input frame_kind,
                input payload_length, input frame_end, input status,
                input run_last, output ready);
endinterface

`default_nettype wire

### rtl/sfd_cfg_if.sv
// Configuration write channel of the serial frame deframer.
// Carries valid, ready, a register index and write data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/serial_frame_deframer_sum_check.sv
// Channel  Role    Payload
// rx_i     sink    rx_byte[7:0]
// res_o    source  data_byte, byte_index, frame_kind, payload_length, frame_end,
//                  status, run_last
// cfg_i    sink    index[1:0], data[15:0]; always ready
//
// A byte is parsed from the input register that it is taken into, so a byte
// that gives at most one result passes at one per cycle while the result side
// takes results. The frame-kind byte gives two results and needs an empty
// two-entry result buffer; the byte after it waits while the pair drains.
// Reset clears the parser to hunting and loads the register defaults. A stall
// on the result side holds two results, then backs up into the input register
// and drops rx_i.ready.
//
// Top level of the serial frame deframer with additive checksum.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_cfg_if, sfd_core, sfd_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_sum_check (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfd_in_if.sink    rx_i,
  sfd_out_if.source res_o,
  sfd_cfg_if.sink   cfg_i
);

  logic          ir_valid_q;
  logic [7:0]    ir_byte_q;
  logic [2:0]    min_sync_run_q;
  logic [15:0]   max_payload_q;
  logic          fire;
  logic [1:0]    n_res;
  logic [1:0]    buf_count;
  logic [1:0]    push_n;
  sfd_pkg::res_t res0;
  sfd_pkg::res_t res1;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sync_run_q <= sfd_pkg::MIN_SYNC_RUN_RESET;
      max_payload_q  <= sfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sfd_pkg::CFG_MIN_SYNC_RUN: min_sync_run_q <= cfg_i.data[2:0];
        sfd_pkg::CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // The held byte moves on once the buffer has room for all its results.
  assign fire       = ir_valid_q && (({1'b0, buf_count} + {1'b0, n_res}) <= 3'd2);
  assign rx_i.ready = !ir_valid_q || fire;
  assign push_n     = fire ? n_res : 2'd0;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      ir_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      ir_byte_q <= rx_i.rx_byte;
    end
  end

  sfd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .byte_i         (ir_byte_q),
    .min_sync_run_i (min_sync_run_q),
    .max_payload_i  (max_payload_q),
    .n_res_o        (n_res),
    .res0_o         (res0),
    .res1_o         (res1)
  );

  sfd_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .count_o  (buf_count),
    .res_o    (res_o)
  );

`ifndef SYNTHESIS
  // The buffer never holds more than two results.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_count != 2'd3)
    else $error("result buffer count out of range");

  // A two-result byte leaves the buffer full in the next cycle.
  a_pair_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && n_res == 2'd2) |=> (buf_count == 2'd2))
    else $error("frame opening results not both buffered");

  // A closing result is always the last one of its byte.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> res_o.run_last)
    else $error("frame end without run_last");

  // A verdict is given exactly on a closing result.
  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.frame_end == (res_o.status != sfd_pkg::ST_PROGRESS)))
    else $error("status and frame_end disagree");
`endif

endmodule

`default_nettype wire

### rtl/sfd_core.sv
// Frame parser of the serial frame deframer: phase machine, checksum,
// length and index counters. Builds up to two results per byte. Uses sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic [2:0]     min_sync_run_i,
  input  wire logic [15:0]    max_payload_i,
  output logic      [1:0]     n_res_o,
  output sfd_pkg::res_t       res0_o,
  output sfd_pkg::res_t       res1_o
);

  sfd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      sync_q, sync_d;
  sfd_pkg::kind_e  kind_q, kind_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     left_q, left_d;
  logic [16:0]     idx_q, idx_d;

  logic              hunting;
  logic              open_w;
  logic              frm_end;
  sfd_pkg::status_e  frm_status;
  logic [2:0]        need;
  logic [15:0]       len_new;
  logic [15:0]       left_dec;

  // Decode of the current byte: frame opening, new length and the verdict.
  always_comb begin
    need       = (min_sync_run_i == 3'd0) ? 3'd1 : min_sync_run_i;
    hunting    = 1'b0;
    frm_end    = 1'b0;
    frm_status = sfd_pkg::ST_PROGRESS;
    len_new    = (phase_q == sfd_pkg::PH_LENH) ? {byte_i, 8'h00} :
                 (phase_q == sfd_pkg::PH_LEN8) ? {8'h00, byte_i} :
                 {len_q[15:8], byte_i};
    unique case (phase_q)
      sfd_pkg::PH_CMD, sfd_pkg::PH_LENH, sfd_pkg::PH_PAYLOAD, sfd_pkg::PH_ETX: begin
      end
      sfd_pkg::PH_LEN8, sfd_pkg::PH_LENL: begin
        if (len_new > max_payload_i) begin
          frm_end    = 1'b1;
          frm_status = sfd_pkg::ST_TOO_LONG;
        end
      end
      sfd_pkg::PH_CSUM: begin
        frm_end    = 1'b1;
        frm_status = (byte_i == sum_q) ? sfd_pkg::ST_GOOD : sfd_pkg::ST_BAD_CSUM;
      end
      sfd_pkg::PH_CSUMBAD: begin
        frm_end    = 1'b1;
        frm_status = sfd_pkg::ST_BAD_ETX;
      end
      default: begin
        hunting = 1'b1;
      end
    endcase
    open_w   = hunting && (byte_i != sfd_pkg::SYNC_BYTE) && (sync_q >= need);
    left_dec = left_q - 16'd1;
  end

  // Next state of the phase machine and its counters.
  always_comb begin
    phase_d = phase_q;
    sync_d  = sync_q;
    kind_d  = kind_q;
    sum_d   = sum_q;
    len_d   = len_q;
    left_d  = left_q;
    idx_d   = idx_q;
    if (hunting) begin
      phase_d = sfd_pkg::PH_HUNT;
      if (byte_i == sfd_pkg::SYNC_BYTE) begin
        if (sync_q < sfd_pkg::SYNC_RUN_MAX) begin
          sync_d = sync_q + 3'd1;
        end
      end else if (!open_w) begin
        sync_d = 3'd0;
      end else begin
        kind_d  = (byte_i == sfd_pkg::KIND_EXT_BYTE) ? sfd_pkg::KIND_EXT :
                  (byte_i == sfd_pkg::KIND_CMD_BYTE) ? sfd_pkg::KIND_CMD :
                  sfd_pkg::KIND_NORMAL;
        len_d   = 16'd0;
        left_d  = 16'd0;
        sum_d   = sfd_pkg::SYNC_BYTE + byte_i;
        sync_d  = 3'd0;
        phase_d = sfd_pkg::PH_CMD;
        idx_d   = 17'd2;
      end
    end else begin
      idx_d = idx_q + 17'd1;
      unique case (phase_q)
        sfd_pkg::PH_CMD: begin
          sum_d   = sum_q + byte_i;
          phase_d = (kind_q == sfd_pkg::KIND_CMD) ? sfd_pkg::PH_CSUM :
                    (kind_q == sfd_pkg::KIND_EXT) ? sfd_pkg::PH_LENH :
                    sfd_pkg::PH_LEN8;
        end
        sfd_pkg::PH_LENH: begin
          sum_d   = sum_q + byte_i;
          len_d   = len_new;
          phase_d = sfd_pkg::PH_LENL;
        end
        sfd_pkg::PH_LEN8, sfd_pkg::PH_LENL: begin
          sum_d = sum_q + byte_i;
          len_d = len_new;
          if (!frm_end) begin
            left_d  = len_new;
            phase_d = (len_new != 16'd0) ? sfd_pkg::PH_PAYLOAD : sfd_pkg::PH_ETX;
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          sum_d  = sum_q + byte_i;
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = sfd_pkg::PH_ETX;
          end
        end
        sfd_pkg::PH_ETX: begin
          sum_d   = sum_q + byte_i;
          phase_d = (byte_i == sfd_pkg::ETX_BYTE) ? sfd_pkg::PH_CSUM : sfd_pkg::PH_CSUMBAD;
        end
        default: begin
        end
      endcase
      // A verdict sends the parser back to hunting.
      if (frm_end) begin
        phase_d = sfd_pkg::PH_HUNT;
        sync_d  = 3'd0;
      end
    end
  end

  // Results of the current byte, carrying kind and length after the update.
  always_comb begin
    n_res_o = 2'd0;
    res0_o  = '{data_byte: byte_i, byte_index: idx_q, frame_kind: kind_d,
                payload_length: len_d, frame_end: frm_end, status: frm_status,
                run_last: 1'b1};
    res1_o  = '{data_byte: byte_i, byte_index: 17'd1, frame_kind: kind_d,
                payload_length: 16'd0, frame_end: 1'b0, status: sfd_pkg::ST_PROGRESS,
                run_last: 1'b1};
    if (hunting) begin
      if (open_w) begin
        n_res_o = 2'd2;
        res0_o  = '{data_byte: sfd_pkg::SYNC_BYTE, byte_index: 17'd0, frame_kind: kind_d,
                    payload_length: 16'd0, frame_end: 1'b0,
                    status: sfd_pkg::ST_PROGRESS, run_last: 1'b0};
      end
    end else begin
      n_res_o = 2'd1;
    end
  end

  // State registers advance only when the byte is passed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HUNT;
      sync_q  <= 3'd0;
      kind_q  <= sfd_pkg::KIND_NORMAL;
      sum_q   <= 8'd0;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
      idx_q   <= 17'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sync_q  <= sync_d;
      kind_q  <= kind_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sfd_out_buf.sv
// Two-entry result buffer of the serial frame deframer. Takes up to two
// results per cycle and presents them in order. Uses sfd_pkg and sfd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    push_n_i,
  input  sfd_pkg::res_t      push0_i,
  input  sfd_pkg::res_t      push1_i,
  output logic      [1:0]    count_o,
  sfd_out_if.source          res_o
);

  logic [1:0]    count_q, count_d;
  sfd_pkg::res_t slot0_q, slot0_d;
  sfd_pkg::res_t slot1_q, slot1_d;
  logic          pop;
  logic [1:0]    rem_count;
  sfd_pkg::res_t rem0;

  assign pop       = (count_q != 2'd0) && res_o.ready;
  assign rem_count = count_q - {1'b0, pop};
  assign rem0      = pop ? slot1_q : slot0_q;

  // Drop the head on a transaction, then append the new results behind.
  always_comb begin
    slot0_d = rem0;
    slot1_d = slot1_q;
    unique case (rem_count)
      2'd0: begin
        slot0_d = push0_i;
        slot1_d = push1_i;
      end
      2'd1: begin
        slot1_d = push0_i;
      end
      default: begin
      end
    endcase
    count_d = rem_count + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // Head entry drives the result channel.
  assign count_o              = count_q;
  assign res_o.valid          = (count_q != 2'd0);
  assign res_o.data_byte      = slot0_q.data_byte;
  assign res_o.byte_index     = slot0_q.byte_index;
  assign res_o.frame_kind     = slot0_q.frame_kind;
  assign res_o.payload_length = slot0_q.payload_length;
  assign res_o.frame_end      = slot0_q.frame_end;
  assign res_o.status         = slot0_q.status;
  assign res_o.run_last       = slot0_q.run_last;

endmodule

`default_nettype wire
